>>> design/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Types and constants shared by the expression stack machine modules.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int unsigned DW = 64;

  typedef struct packed {
    logic [7:0]           operation;
    logic signed [DW-1:0] operand;
    logic [DW-1:0]        reg_value;
    logic                 first_op;
    logic                 last_op;
  } dsm_in_t;

  typedef struct packed {
    logic [DW-1:0] top_value;
    logic [4:0]    stack_depth;
    logic          branch_taken;
    logic [2:0]    status;
    logic          done_res;
    logic [1:0]    location_kind;
    logic [DW-1:0] location_value;
  } dsm_out_t;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_UNSUP = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  // location kinds
  localparam logic [1:0] LOC_ADDR = 2'd0;
  localparam logic [1:0] LOC_REG  = 2'd1;
  localparam logic [1:0] LOC_LIT  = 2'd2;

  // opcodes
  localparam logic [7:0] OP_ADDR    = 8'h03;
  localparam logic [7:0] OP_C1U     = 8'h08;
  localparam logic [7:0] OP_C1S     = 8'h09;
  localparam logic [7:0] OP_C2U     = 8'h0a;
  localparam logic [7:0] OP_C2S     = 8'h0b;
  localparam logic [7:0] OP_C4U     = 8'h0c;
  localparam logic [7:0] OP_C4S     = 8'h0d;
  localparam logic [7:0] OP_C8U     = 8'h0e;
  localparam logic [7:0] OP_C8S     = 8'h0f;
  localparam logic [7:0] OP_CONSTU  = 8'h10;
  localparam logic [7:0] OP_CONSTS  = 8'h11;
  localparam logic [7:0] OP_DUP     = 8'h12;
  localparam logic [7:0] OP_DROP    = 8'h13;
  localparam logic [7:0] OP_OVER    = 8'h14;
  localparam logic [7:0] OP_PICK    = 8'h15;
  localparam logic [7:0] OP_SWAP    = 8'h16;
  localparam logic [7:0] OP_ROT     = 8'h17;
  localparam logic [7:0] OP_ABS     = 8'h19;
  localparam logic [7:0] OP_AND     = 8'h1a;
  localparam logic [7:0] OP_DIV     = 8'h1b;
  localparam logic [7:0] OP_MINUS   = 8'h1c;
  localparam logic [7:0] OP_MOD     = 8'h1d;
  localparam logic [7:0] OP_MUL     = 8'h1e;
  localparam logic [7:0] OP_NEG     = 8'h1f;
  localparam logic [7:0] OP_NOT     = 8'h20;
  localparam logic [7:0] OP_OR      = 8'h21;
  localparam logic [7:0] OP_PLUS    = 8'h22;
  localparam logic [7:0] OP_PLUSU   = 8'h23;
  localparam logic [7:0] OP_SHL     = 8'h24;
  localparam logic [7:0] OP_SHR     = 8'h25;
  localparam logic [7:0] OP_SHRA    = 8'h26;
  localparam logic [7:0] OP_XOR     = 8'h27;
  localparam logic [7:0] OP_BRA     = 8'h28;
  localparam logic [7:0] OP_EQ      = 8'h29;
  localparam logic [7:0] OP_GE      = 8'h2a;
  localparam logic [7:0] OP_GT      = 8'h2b;
  localparam logic [7:0] OP_LE      = 8'h2c;
  localparam logic [7:0] OP_LT      = 8'h2d;
  localparam logic [7:0] OP_NE      = 8'h2e;
  localparam logic [7:0] OP_SKIP    = 8'h2f;
  localparam logic [7:0] OP_LIT0    = 8'h30;
  localparam logic [7:0] OP_LIT31   = 8'h4f;
  localparam logic [7:0] OP_REG0    = 8'h50;
  localparam logic [7:0] OP_REG31   = 8'h6f;
  localparam logic [7:0] OP_BREG0   = 8'h70;
  localparam logic [7:0] OP_BREG31  = 8'h8f;
  localparam logic [7:0] OP_REGX    = 8'h90;
  localparam logic [7:0] OP_BREGX   = 8'h92;
  localparam logic [7:0] OP_NOP     = 8'h96;
  localparam logic [7:0] OP_STKVAL  = 8'h9f;

  // command broadcast along the row of stack cells
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP,
    CMD_WTOP,
    CMD_BINOP,
    CMD_SWAP,
    CMD_ROT
  } cell_cmd_t;

  // place of a cell in the row, counted from the top of stack
  typedef enum logic [1:0] {
    POS_TOP,
    POS_SECOND,
    POS_THIRD,
    POS_REST
  } cell_pos_t;

  // long arithmetic operation kinds
  typedef enum logic [1:0] {
    LK_MUL,
    LK_DIV,
    LK_MOD
  } long_kind_t;

  typedef struct packed {
    logic       start;
    long_kind_t kind;
  } long_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LONG,
    S_FIN
  } dsm_state_t;

endpackage

>>> design/dwarf_expression_stack_machine_top.sv
// ----------------------------------------------------------------------------
// dwarf_expression_stack_machine_top
// Executes one pre-decoded DWARF expression operation per transaction.
// ----------------------------------------------------------------------------
//  channel  ports                         payload
//  input    in_valid/in_ready/in_data     dsm_in_t
//  result   out_valid/out_ready/out_data  dsm_out_t
//
//  Most operations are captured, then executed against the cell row.
//  mul, div and mod first run in the bit-serial arithmetic unit (one bit a
//  cycle over 64 bits), then a finishing state commits the result.
//  Synchronous active-low reset empties the stack; no clearing pass.
//  A new transaction is taken while a result waits; commit stalls until the
//  output register is free.
module dwarf_expression_stack_machine_top import dsm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dsm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dsm_out_t out_data
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);

  dsm_state_t    state_r, state_nxt;
  dsm_in_t       item_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    lk_r, lk_nxt;
  logic [DW-1:0] lv_r, lv_nxt;
  logic          out_valid_r;
  dsm_out_t      out_r, res;

  logic [DW-1:0] cell_val [STACK_DEPTH];
  cell_cmd_t     cmd;
  cell_cmd_t     row_cmd;
  logic [DW-1:0] bus;

  long_req_t     lreq;
  logic          long_done;
  logic [DW-1:0] long_res;

  logic          commit, out_free, need_long;
  long_kind_t    lkind;

  // operation decode
  logic [7:0]    op;
  logic [DW-1:0] opnd, a, b, c0, c1, binres, pick_val, top_n;
  logic [CW-1:0] cnt_e;
  logic [1:0]    lk_e;
  logic [DW-1:0] lv_e;
  logic          push_req, is_bin, bsmall;
  logic [DW-1:0] push_v;
  logic [2:0]    st;
  logic          br;
  logic [7:0]    pick_n;

  // cell row
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    localparam cell_pos_t POS = (i == 0) ? POS_TOP : (i == 1) ? POS_SECOND :
                                (i == 2) ? POS_THIRD : POS_REST;
    dsm_cell u_cell (
      .clk     (clk),
      .cmd_i   (row_cmd),
      .pos_i   (POS),
      .above_i ((i == 0) ? bus : cell_val[(i == 0) ? 0 : i - 1]),
      .below_i ((i == STACK_DEPTH - 1) ? cell_val[i] :
                cell_val[(i == STACK_DEPTH - 1) ? i : i + 1]),
      .bus_i   (bus),
      .value_o (cell_val[i])
    );
  end

  dsm_long u_long (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_i    (lreq),
    .a_i      (a),
    .b_i      (b),
    .done_o   (long_done),
    .result_o (long_res)
  );

  assign op     = item_r.operation;
  assign opnd   = item_r.operand;
  assign c0     = cell_val[0];
  assign c1     = cell_val[1];
  assign a      = c1;
  assign b      = c0;
  assign cnt_e  = item_r.first_op ? '0 : cnt_r;
  assign lk_e   = item_r.first_op ? LOC_ADDR : lk_r;
  assign lv_e   = item_r.first_op ? '0 : lv_r;
  assign pick_n = opnd[7:0];
  assign pick_val = cell_val[pick_n[IW-1:0]];
  assign bsmall = (b[DW-1:6] == '0);

  // binary operation result
  always_comb begin
    case (op)
      OP_AND:   binres = a & b;
      OP_MINUS: binres = a - b;
      OP_OR:    binres = a | b;
      OP_PLUS:  binres = a + b;
      OP_SHL:   binres = bsmall ? (a << b[5:0]) : '0;
      OP_SHR:   binres = bsmall ? (a >> b[5:0]) : '0;
      OP_SHRA:  binres = bsmall ? DW'($signed(a) >>> b[5:0]) : {DW{a[DW-1]}};
      OP_XOR:   binres = a ^ b;
      OP_EQ:    binres = DW'(a == b);
      OP_GE:    binres = DW'($signed(a) >= $signed(b));
      OP_GT:    binres = DW'($signed(a) > $signed(b));
      OP_LE:    binres = DW'($signed(a) <= $signed(b));
      OP_LT:    binres = DW'($signed(a) < $signed(b));
      OP_NE:    binres = DW'(a != b);
      default:  binres = long_res;
    endcase
  end

  // execute the operation against the current stack
  always_comb begin
    cmd       = CMD_HOLD;
    bus       = '0;
    cnt_nxt   = cnt_e;
    lk_nxt    = lk_e;
    lv_nxt    = lv_e;
    st        = ST_OK;
    br        = 1'b0;
    top_n     = c0;
    push_req  = 1'b0;
    push_v    = '0;
    is_bin    = 1'b0;
    need_long = 1'b0;
    lkind     = LK_MUL;
    unique case (op) inside
      [OP_LIT0:OP_LIT31]: begin
        push_req = 1'b1;
        push_v   = DW'(op - OP_LIT0);
      end
      [OP_REG0:OP_REG31]: begin
        lk_nxt = LOC_REG;
        lv_nxt = DW'(op - OP_REG0);
      end
      [OP_BREG0:OP_BREG31], OP_BREGX: begin
        push_req = 1'b1;
        push_v   = item_r.reg_value + opnd;
      end
      OP_ADDR, OP_C8U, OP_C8S, OP_CONSTU, OP_CONSTS: begin
        push_req = 1'b1;
        push_v   = opnd;
      end
      OP_C1U: begin push_req = 1'b1; push_v = DW'(opnd[7:0]); end
      OP_C2U: begin push_req = 1'b1; push_v = DW'(opnd[15:0]); end
      OP_C4U: begin push_req = 1'b1; push_v = DW'(opnd[31:0]); end
      OP_C1S: begin push_req = 1'b1; push_v = {{(DW-8){opnd[7]}}, opnd[7:0]}; end
      OP_C2S: begin push_req = 1'b1; push_v = {{(DW-16){opnd[15]}}, opnd[15:0]}; end
      OP_C4S: begin push_req = 1'b1; push_v = {{(DW-32){opnd[31]}}, opnd[31:0]}; end
      OP_DUP: begin
        if (cnt_e < CW'(1)) st = ST_UNDER;
        else begin push_req = 1'b1; push_v = c0; end
      end
      OP_DROP: begin
        if (cnt_e < CW'(1)) st = ST_UNDER;
        else begin cmd = CMD_POP; cnt_nxt = cnt_e - CW'(1); top_n = c1; end
      end
      OP_PICK: begin
        if (32'(pick_n) >= 32'(cnt_e)) st = ST_UNDER;
        else begin push_req = 1'b1; push_v = pick_val; end
      end
      OP_OVER: begin
        if (cnt_e < CW'(2)) st = ST_UNDER;
        else begin push_req = 1'b1; push_v = c1; end
      end
      OP_SWAP: begin
        if (cnt_e < CW'(2)) st = ST_UNDER;
        else begin cmd = CMD_SWAP; top_n = c1; end
      end
      OP_ROT: begin
        if (cnt_e < CW'(3)) st = ST_UNDER;
        else begin cmd = CMD_ROT; bus = c0; top_n = c1; end
      end
      OP_ABS, OP_NEG, OP_NOT, OP_PLUSU: begin
        if (cnt_e < CW'(1)) st = ST_UNDER;
        else begin
          cmd = CMD_WTOP;
          case (op)
            OP_ABS:  bus = c0[DW-1] ? (DW'(0) - c0) : c0;
            OP_NEG:  bus = DW'(0) - c0;
            OP_NOT:  bus = ~c0;
            default: bus = c0 + opnd;
          endcase
          top_n = bus;
        end
      end
      OP_AND, OP_DIV, OP_MINUS, OP_MOD, OP_MUL, OP_OR, OP_PLUS, OP_SHL,
      OP_SHR, OP_SHRA, OP_XOR, OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE: begin
        if (cnt_e < CW'(2)) st = ST_UNDER;
        else if ((op == OP_DIV || op == OP_MOD) && b == '0) st = ST_DIV0;
        else is_bin = 1'b1;
      end
      OP_SKIP: br = 1'b1;
      OP_BRA: begin
        if (cnt_e < CW'(1)) st = ST_UNDER;
        else begin
          cmd = CMD_POP; cnt_nxt = cnt_e - CW'(1); top_n = c1; br = (c0 != '0);
        end
      end
      OP_NOP: ;
      OP_REGX: begin
        lk_nxt = LOC_REG;
        lv_nxt = opnd;
      end
      OP_STKVAL: begin
        if (cnt_e < CW'(1)) st = ST_UNDER;
        else begin lk_nxt = LOC_LIT; lv_nxt = c0; end
      end
      default: st = ST_UNSUP;
    endcase
    // long operations run in the arithmetic unit first
    if (is_bin) begin
      if (op == OP_MUL || op == OP_DIV || op == OP_MOD) begin
        need_long = (state_r == S_EXEC);
        lkind = (op == OP_MUL) ? LK_MUL : (op == OP_DIV) ? LK_DIV : LK_MOD;
      end
      cmd     = CMD_BINOP;
      bus     = binres;
      top_n   = binres;
      cnt_nxt = cnt_e - CW'(1);
    end
    if (push_req) begin
      if (cnt_e == CW'(STACK_DEPTH)) st = ST_OVER;
      else begin
        cmd     = CMD_PUSH;
        bus     = push_v;
        top_n   = push_v;
        cnt_nxt = cnt_e + CW'(1);
      end
    end
  end

  // assemble the result
  always_comb begin
    res.top_value      = (cnt_nxt != '0) ? top_n : '0;
    res.stack_depth    = 5'(cnt_nxt);
    res.branch_taken   = br;
    res.done_res       = item_r.last_op;
    res.location_kind  = LOC_ADDR;
    res.location_value = '0;
    res.status         = st;
    if (item_r.last_op) begin
      if (lk_nxt == LOC_ADDR) begin
        if (cnt_nxt == '0) begin
          if (st == ST_OK) res.status = ST_EMPTY;
        end else begin
          res.location_value = top_n;
        end
      end else begin
        res.location_kind  = lk_nxt;
        res.location_value = lv_nxt;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (need_long) state_nxt = S_LONG;
        else if (out_free) state_nxt = S_IDLE;
      end
      S_LONG: if (long_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    commit     = 1'b0;
    lreq.start = 1'b0;
    lreq.kind  = lkind;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        lreq.start = need_long;
        commit     = !need_long && out_free;
      end
      S_LONG: ;
      S_FIN:  commit = out_free;
      default: ;
    endcase
  end

  // hand the command to the row only on commit; hold the row otherwise
  assign row_cmd = commit ? cmd : CMD_HOLD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lk_r        <= LOC_ADDR;
      lv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cnt_r       <= cnt_nxt;
        lk_r        <= lk_nxt;
        lv_r        <= lv_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the transaction and the result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    if (commit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/dsm_cell.sv
// ----------------------------------------------------------------------------
// dsm_cell
// One stack entry; loads from its neighbours or the shared bus on command.
// ----------------------------------------------------------------------------
module dsm_cell import dsm_pkg::*; (
  input  logic          clk,
  input  cell_cmd_t     cmd_i,
  input  cell_pos_t     pos_i,
  input  logic [DW-1:0] above_i,
  input  logic [DW-1:0] below_i,
  input  logic [DW-1:0] bus_i,
  output logic [DW-1:0] value_o
);

  logic [DW-1:0] value_r;
  logic [DW-1:0] value_nxt;

  // select the source for this entry
  always_comb begin
    value_nxt = value_r;
    unique case (cmd_i)
      CMD_HOLD:  value_nxt = value_r;
      CMD_PUSH:  value_nxt = above_i;
      CMD_POP:   value_nxt = below_i;
      CMD_WTOP:  value_nxt = (pos_i == POS_TOP) ? bus_i : value_r;
      CMD_BINOP: value_nxt = (pos_i == POS_TOP) ? bus_i : below_i;
      CMD_SWAP: begin
        if (pos_i == POS_TOP) value_nxt = below_i;
        else if (pos_i == POS_SECOND) value_nxt = above_i;
      end
      CMD_ROT: begin
        if (pos_i == POS_TOP || pos_i == POS_SECOND) value_nxt = below_i;
        else if (pos_i == POS_THIRD) value_nxt = bus_i;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

>>> design/dsm_long.sv
// ----------------------------------------------------------------------------
// dsm_long
// Bit-serial multiply, signed divide and unsigned modulo, one bit a cycle.
// ----------------------------------------------------------------------------
module dsm_long import dsm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  long_req_t     req_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] result_o
);

  localparam int unsigned SW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  long_kind_t    kind_r, kind_nxt;
  logic          neg_r, neg_nxt;
  logic [DW-1:0] acc_r, acc_nxt;   // product or remainder
  logic [DW-1:0] x_r, x_nxt;       // multiplicand or dividend/quotient
  logic [DW-1:0] y_r, y_nxt;       // multiplier or divisor
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;

  // one iteration step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    kind_nxt = kind_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_sh   = {acc_r, x_r[DW-1]};
    rem_sub  = rem_sh - {1'b0, y_r};
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      kind_nxt = req_i.kind;
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      if (req_i.kind == LK_DIV) begin
        x_nxt   = a_i[DW-1] ? (DW'(0) - a_i) : a_i;
        y_nxt   = b_i[DW-1] ? (DW'(0) - b_i) : b_i;
        neg_nxt = a_i[DW-1] ^ b_i[DW-1];
      end else begin
        x_nxt = a_i;
        y_nxt = b_i;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + SW'(1);
      if (kind_r == LK_MUL) begin
        if (y_r[0]) acc_nxt = acc_r + x_r;
        x_nxt = {x_r[DW-2:0], 1'b0};
        y_nxt = {1'b0, y_r[DW-1:1]};
      end else begin
        if (!rem_sub[DW]) begin
          acc_nxt = rem_sub[DW-1:0];
          x_nxt   = {x_r[DW-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh[DW-1:0];
          x_nxt   = {x_r[DW-2:0], 1'b0};
        end
      end
      if (cnt_r == SW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
  end

  // pick the result for the kind in hand
  always_comb begin
    case (kind_r)
      LK_MUL:  result_o = acc_r;
      LK_DIV:  result_o = neg_r ? (DW'(0) - x_r) : x_r;
      default: result_o = acc_r;
    endcase
  end

  assign done_o = done_r;

endmodule
